// File: rtl/wmpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpf_pkg
// Shared types and constants for the window median pixel filter.
// ----------------------------------------------------------------------------
package wmpf_pkg;

  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_WINDOW  = 15;

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int WIN_CAP     = MAX_WINDOW * MAX_WINDOW;
  // only the lowest half of the window (plus the median) must be kept
  localparam int CHAIN_DEPTH = WIN_CAP / 2 + 1;
  localparam int TGT_W       = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int WIN_W       = $clog2(MAX_WINDOW + 1);

  localparam int POS_W       = 6;   // row / col field width
  localparam int CFG_DIM_W   = 7;   // image_width / image_height
  localparam int CFG_WIN_W   = 4;   // window_size
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int COORD_W     = 8;   // signed window coordinates
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int KEY_W       = 10;  // sum of three channels

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              command;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
  } out_item_t;

  // broadcast from the sequencer to every rank cell
  typedef struct packed {
    logic             clr;
    logic             en;
    logic [KEY_W-1:0] key;
    logic [PIX_W-1:0] pix;
  } rank_ins_t;

  // what one cell hands to the next
  typedef struct packed {
    logic             valid;
    logic             less;
    logic [KEY_W-1:0] key;
    logic [PIX_W-1:0] pix;
  } cell_link_t;

endpackage

// File: rtl/wmpf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpf_ram
// Generic single-port RAM, synchronous write, registered read.
// ----------------------------------------------------------------------------
module wmpf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/wmpf_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpf_cell
// One insertion-sort cell: holds a pixel and its brightness key.
// ----------------------------------------------------------------------------
module wmpf_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wmpf_pkg::rank_ins_t      ins,
  input  wmpf_pkg::cell_link_t     prev,
  output wmpf_pkg::cell_link_t     link
);
  import wmpf_pkg::*;

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic             less;

  // strict compare keeps equal keys in arrival (raster) order
  assign less = !valid_r || (ins.key < key_r);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    pix_nxt   = pix_r;
    if (ins.clr) begin
      valid_nxt = 1'b0;
    end else if (ins.en && less) begin
      if (prev.less) begin
        valid_nxt = prev.valid;
        key_nxt   = prev.key;
        pix_nxt   = prev.pix;
      end else begin
        valid_nxt = 1'b1;
        key_nxt   = ins.key;
        pix_nxt   = ins.pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r <= key_nxt;
    pix_r <= pix_nxt;
  end

  assign link.valid = valid_r;
  assign link.less  = less;
  assign link.key   = key_r;
  assign link.pix   = pix_r;

endmodule

// File: rtl/wmpf_rank_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmpf_rank_chain
// Row of sort cells kept in ascending brightness order; picks the ranked pixel.
// ----------------------------------------------------------------------------
module wmpf_rank_chain (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wmpf_pkg::rank_ins_t        ins,
  input  logic [wmpf_pkg::TGT_W-1:0] sel,
  output logic [wmpf_pkg::PIX_W-1:0] sel_pix
);
  import wmpf_pkg::*;

  cell_link_t link [0:CHAIN_DEPTH-1];
  logic [PIX_W-1:0] pix_arr [0:CHAIN_DEPTH-1];

  for (genvar g = 0; g < CHAIN_DEPTH; g++) begin : g_cell
    cell_link_t prev;
    if (g == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = link[g-1];
    end

    wmpf_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ins   (ins),
      .prev  (prev),
      .link  (link[g])
    );

    assign pix_arr[g] = link[g].pix;
  end

  assign sel_pix = pix_arr[sel];

endmodule

// File: rtl/window_median_pixel_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_median_pixel_filter
// Pixel frame store with an n x n windowed median query ranked by brightness.
// ----------------------------------------------------------------------------
//  channel | ports                          | transaction
//  in      | in_valid/in_ready/in_data      | write pixel or query median
//  out     | out_valid/out_ready/out_data   | median pixel, one per query
//  cfg     | cfg_we/cfg_index/cfg_wdata     | register write, no wait
//
//  A query reads all n*n window pixels (n = effective window size) through
//  the single frame store read port: one window pixel a cycle is read and
//  inserted into the rank chain.
//  rst_n is synchronous; the frame store is not cleared.
//  Writes are taken while a result waits on out; a finished query holds until
//  the output register frees up.
// ----------------------------------------------------------------------------
module window_median_pixel_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  wmpf_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output wmpf_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [wmpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wmpf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wmpf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_DIM_W-1:0] img_w_r, img_h_r;
  logic [CFG_WIN_W-1:0] win_r;

  logic [CFG_DIM_W-1:0] eff_w, eff_h;
  logic [WIN_W-1:0]     eff_n;

  logic [WIN_W-1:0]          n_r, n_nxt;
  logic [WIN_W-1:0]          x_r, x_nxt, y_r, y_nxt;
  logic signed [COORD_W-1:0] base_r_r, base_r_nxt, base_c_r, base_c_nxt;
  logic [TGT_W-1:0]          target_r, target_nxt;
  logic                      pend_r, pend_nxt;
  logic                      inside_r, inside_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_data_r, out_data_nxt;

  logic                      in_acc;
  logic                      wr_ok;
  logic signed [COORD_W-1:0] scan_r, scan_c;
  logic                      scan_inside;
  logic                      scan_last;
  logic [ADDR_W-1:0]         wr_addr, scan_addr, ram_addr;
  logic                      ram_we;
  logic [PIX_W-1:0]          ram_wdata, ram_rdata;
  logic [PIX_W-1:0]          ins_pix;
  logic [PIX_W-1:0]          sel_pix;
  logic [2*WIN_W-1:0]        win_area;
  logic [WIN_W-1:0]          half_n;
  rank_ins_t                 ins;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= CFG_DIM_W'(64);
      img_h_r <= CFG_DIM_W'(64);
      win_r   <= CFG_WIN_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r <= cfg_wdata[CFG_DIM_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r <= cfg_wdata[CFG_DIM_W-1:0];
        CFG_WINDOW_SIZE:  win_r   <= cfg_wdata[CFG_WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes to the store and window limits
  always_comb begin
    eff_w = img_w_r;
    if (32'(img_w_r) > MAX_WIDTH) begin
      eff_w = CFG_DIM_W'(MAX_WIDTH);
    end
    eff_h = img_h_r;
    if (32'(img_h_r) > MAX_HEIGHT) begin
      eff_h = CFG_DIM_W'(MAX_HEIGHT);
    end
    if (win_r == '0) begin
      eff_n = WIN_W'(1);
    end else if (32'(win_r) > MAX_WINDOW) begin
      eff_n = WIN_W'(MAX_WINDOW);
    end else begin
      eff_n = WIN_W'(win_r);
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;

  // pixel write path
  assign wr_ok   = (CFG_DIM_W'(in_data.row) < eff_h) && (CFG_DIM_W'(in_data.col) < eff_w);
  assign wr_addr = ADDR_W'(in_data.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_data.col);

  // window scan position
  assign scan_r      = base_r_r + $signed(COORD_W'(x_r));
  assign scan_c      = base_c_r + $signed(COORD_W'(y_r));
  assign scan_inside = !scan_r[COORD_W-1] && !scan_c[COORD_W-1]
                    && ($unsigned(scan_r) < COORD_W'(eff_h))
                    && ($unsigned(scan_c) < COORD_W'(eff_w));
  assign scan_addr   = ADDR_W'($unsigned(scan_r)) * ADDR_W'(MAX_WIDTH)
                     + ADDR_W'($unsigned(scan_c));
  assign scan_last   = (x_r == n_r - WIN_W'(1)) && (y_r == n_r - WIN_W'(1));

  assign ram_we    = in_acc && (in_data.command == CMD_WRITE) && wr_ok;
  assign ram_addr  = (state_r == ST_IDLE) ? wr_addr : scan_addr;
  assign ram_wdata = {in_data.red, in_data.green, in_data.blue};

  wmpf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // positions outside the image are black
  assign ins_pix = inside_r ? ram_rdata : '0;
  assign ins.clr = in_acc && (in_data.command == CMD_QUERY);
  assign ins.en  = pend_r;
  assign ins.pix = ins_pix;
  assign ins.key = KEY_W'(ins_pix[CHAN_W-1:0]) + KEY_W'(ins_pix[2*CHAN_W-1:CHAN_W])
                 + KEY_W'(ins_pix[3*CHAN_W-1:2*CHAN_W]);

  wmpf_rank_chain u_rank (
    .clk     (clk),
    .rst_n   (rst_n),
    .ins     (ins),
    .sel     (target_r),
    .sel_pix (sel_pix)
  );

  assign half_n   = eff_n >> 1;
  assign win_area = (2*WIN_W)'(eff_n) * (2*WIN_W)'(eff_n);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    base_r_nxt    = base_r_r;
    base_c_nxt    = base_c_r;
    target_nxt    = target_r;
    pend_nxt      = 1'b0;
    inside_nxt    = inside_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.command == CMD_QUERY)) begin
          n_nxt      = eff_n;
          x_nxt      = '0;
          y_nxt      = '0;
          base_r_nxt = $signed(COORD_W'(in_data.row)) - $signed(COORD_W'(half_n));
          base_c_nxt = $signed(COORD_W'(in_data.col)) - $signed(COORD_W'(half_n));
          target_nxt = TGT_W'(win_area >> 1);
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_nxt   = 1'b1;
        inside_nxt = scan_inside;
        if (scan_last) begin
          state_nxt = ST_LAST;
        end else if (y_r == n_r - WIN_W'(1)) begin
          y_nxt = '0;
          x_nxt = x_r + WIN_W'(1);
        end else begin
          y_nxt = y_r + WIN_W'(1);
        end
      end
      ST_LAST: begin
        // final pixel enters the chain this cycle
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {sel_pix[CHAN_W-1:0], sel_pix[2*CHAN_W-1:CHAN_W],
                           sel_pix[3*CHAN_W-1:2*CHAN_W]};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    base_r_r   <= base_r_nxt;
    base_c_r   <= base_c_nxt;
    target_r   <= target_nxt;
    inside_r   <= inside_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // store is only written between queries
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE))
    else $error("frame store written during a query");

  // no pending insertion when a new transaction can start
  a_ready_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !pend_r)
    else $error("rank insertion pending while idle");

  a_last_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LAST) |=> (state_r == ST_HOLD) && !pend_r)
    else $error("query did not finish after last insertion");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) && (!out_valid_r || out_ready) |=> out_valid_r && in_ready)
    else $error("finished query did not produce a result");
`endif

endmodule

// File: tb/window_median_pixel_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_median_pixel_filter_test
// Drives pixel writes and median queries through the filter, using a
// cycle-free model of the frame store and the brightness ranking to
// predict each median. Image size and window size change between phases.
// Both handshakes see random gaps, and the result side holds off for long
// stretches so the input stalls. Windows are pre-filled before each query,
// so no unwritten entry inside the image is ever read.
// ----------------------------------------------------------------------------
module window_median_pixel_filter_test;
  import wmpf_pkg::*;

  localparam int TARGET_CMDS    = 1700;
  localparam int SETTLE_CYCLES  = 240;   // > one full 15x15 query
  localparam int HOLD_CYCLES    = 700;
  localparam int WATCHDOG_LIMIT = 8000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  window_median_pixel_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // configuration as the block sees it
  logic [CFG_DIM_W-1:0] img_w_cfg = 7'd64;
  logic [CFG_DIM_W-1:0] img_h_cfg = 7'd64;
  logic [CFG_WIN_W-1:0] win_cfg   = 4'd3;

  // predicted image contents, and which entries the stimulus has written
  out_item_t        frame_img [STORE_DEPTH];
  bit               filled    [STORE_DEPTH];
  out_item_t        win_pix   [WIN_CAP];
  logic [KEY_W-1:0] win_key   [WIN_CAP];

  in_item_t  pixel_cmd_q [$];
  out_item_t median_q [$];

  int cmds_issued  = 0;
  int cmds_taken   = 0;
  int stim_count   = 0;
  int medians_seen = 0;
  int errors       = 0;
  int phases       = 0;
  int widest_win   = 0;
  int send_wait    = 0;
  int send_calm    = 0;
  int recv_wait    = 0;
  int recv_calm    = 0;
  int hold_left    = 0;
  int quiet_cycles = 0;
  int recv_gap;
  bit took;

  function automatic int eff_cols();
    return (img_w_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(img_w_cfg);
  endfunction

  function automatic int eff_rows();
    return (img_h_cfg > MAX_HEIGHT) ? MAX_HEIGHT : int'(img_h_cfg);
  endfunction

  function automatic int eff_win();
    if (win_cfg == 0) return 1;
    return (win_cfg > MAX_WINDOW) ? MAX_WINDOW : int'(win_cfg);
  endfunction

  function automatic bit in_image(input int r, input int c);
    return r >= 0 && c >= 0 && r < eff_rows() && c < eff_cols();
  endfunction

  // stable rank by brightness; the pixel at rank n*n/2 is the median
  function automatic out_item_t median_at(input int crow, input int ccol);
    int n, total, goal, k, x, y, a, b, r, c, rank;
    out_item_t px;
    n = eff_win();
    total = n * n;
    goal = total / 2;
    k = 0;
    for (x = 0; x < n; x++) begin
      for (y = 0; y < n; y++) begin
        r = crow - n / 2 + x;
        c = ccol - n / 2 + y;
        px = '0;
        if (in_image(r, c)) px = frame_img[r * MAX_WIDTH + c];
        win_pix[k] = px;
        win_key[k] = {2'b00, px.out_blue} + {2'b00, px.out_green} + {2'b00, px.out_red};
        k++;
      end
    end
    for (a = 0; a < total; a++) begin
      rank = 0;
      for (b = 0; b < total; b++) begin
        if (win_key[b] < win_key[a] || (win_key[b] == win_key[a] && b < a)) rank++;
      end
      if (rank == goal) return win_pix[a];
    end
    return '0;
  endfunction

  task automatic apply_to_image(input in_item_t it);
    out_item_t px;
    if (it.command == CMD_WRITE) begin
      if (in_image(int'(it.row), int'(it.col))) begin
        px.out_blue  = it.blue;
        px.out_green = it.green;
        px.out_red   = it.red;
        frame_img[int'(it.row) * MAX_WIDTH + int'(it.col)] = px;
      end
    end else begin
      median_q.push_back(median_at(int'(it.row), int'(it.col)));
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(20, 80);
  endfunction

  // mix of raw values, a coarse palette and equal-brightness pixels for ties
  function automatic out_item_t random_pixel();
    out_item_t px;
    int r, v;
    r = $urandom_range(0, 99);
    v = $urandom_range(0, 255);
    if (r < 40) begin
      px = out_item_t'(PIX_W'($urandom));
    end else if (r < 75) begin
      px.out_blue  = 8'($urandom_range(0, 3) * 85);
      px.out_green = 8'($urandom_range(0, 3) * 85);
      px.out_red   = 8'($urandom_range(0, 3) * 85);
    end else if ($urandom_range(0, 1) == 0) begin
      px.out_blue  = 8'(v);
      px.out_green = 8'(255 - v);
      px.out_red   = 8'h00;
    end else begin
      px.out_blue  = 8'h00;
      px.out_green = 8'(v);
      px.out_red   = 8'(255 - v);
    end
    return px;
  endfunction

  task automatic push_cmd(input logic cmd, input int row, input int col,
                          input out_item_t px);
    in_item_t it;
    it.command = cmd;
    it.row     = POS_W'(row);
    it.col     = POS_W'(col);
    it.blue    = px.out_blue;
    it.green   = px.out_green;
    it.red     = px.out_red;
    pixel_cmd_q.push_back(it);
    cmds_issued++;
    if (cmd == CMD_QUERY) begin
      stim_count++;
    end else if (in_image(row, col)) begin
      filled[row * MAX_WIDTH + col] = 1'b1;
      stim_count++;
    end
  endtask

  // writes every unwritten in-image pixel of the window, then queries it
  task automatic queue_query(input int row, input int col);
    int n, x, y, r, c;
    n = eff_win();
    for (x = 0; x < n; x++) begin
      for (y = 0; y < n; y++) begin
        r = row - n / 2 + x;
        c = col - n / 2 + y;
        if (in_image(r, c) && !filled[r * MAX_WIDTH + c])
          push_cmd(CMD_WRITE, r, c, random_pixel());
      end
    end
    push_cmd(CMD_QUERY, row, col, random_pixel());
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      CFG_IMAGE_WIDTH:  img_w_cfg = CFG_DIM_W'(val);
      CFG_IMAGE_HEIGHT: img_h_cfg = CFG_DIM_W'(val);
      CFG_WINDOW_SIZE:  win_cfg   = CFG_WIN_W'(val);
      default: ;
    endcase
  endtask

  // only touch registers once every transaction has drained
  task automatic set_geometry(input int w, input int h, input int n);
    while (cmds_taken != cmds_issued || median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write(CFG_IMAGE_WIDTH, w);
    cfg_write(CFG_IMAGE_HEIGHT, h);
    cfg_write(CFG_WINDOW_SIZE, n);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    phases++;
    if (eff_win() > widest_win) widest_win = eff_win();
  endtask

  function automatic int rand_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 7)  return 0;
    if (r < 17) return $urandom_range(65, 127);
    if (r < 27) return 64;
    if (r < 33) return 1;
    return $urandom_range(1, 64);
  endfunction

  function automatic int rand_win();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return 0;
    if (r < 60) return $urandom_range(1, 5);
    if (r < 85) return $urandom_range(6, 9);
    return $urandom_range(10, 15);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_to_image(in_data);
        cmds_taken++;
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          in_valid  <= 1'b0;
          send_wait <= send_wait - 1;
        end else if (pixel_cmd_q.size() != 0) begin
          in_data  <= pixel_cmd_q.pop_front();
          in_valid <= 1'b1;
          if (send_calm != 0) begin
            send_calm--;
            send_wait <= 0;
          end else begin
            send_wait <= pick_gap();
            if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(30, 90);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and result-side flow control
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait <= 0;
      hold_left <= 0;
    end else begin
      took = out_valid && out_ready;
      if (took) begin
        medians_seen++;
        if (median_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected median b=%0d g=%0d r=%0d", $realtime,
                     out_data.out_blue, out_data.out_green, out_data.out_red);
        end else begin
          automatic out_item_t want = median_q.pop_front();
          if (out_data.out_blue !== want.out_blue || out_data.out_green !== want.out_green ||
              out_data.out_red !== want.out_red) begin
            errors++;
            if (errors <= 10)
              $display("%0t: median %0d mismatch: exp b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                       $realtime, medians_seen, want.out_blue, want.out_green, want.out_red,
                       out_data.out_blue, out_data.out_green, out_data.out_red);
          end
        end
      end
      if (took && (medians_seen == 40 || medians_seen == 400)) begin
        // long back-pressure so the filter fills and stalls its input
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait <= recv_wait - 1;
        out_ready <= 1'b0;
      end else if (took || $urandom_range(0, 15) == 0) begin
        if (recv_calm != 0) begin
          recv_calm--;
          recv_gap = 0;
        end else begin
          recv_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(30, 90);
        end
        recv_wait <= recv_gap;
        out_ready <= (recv_gap == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog: no transaction on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ops, row, col;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // tiny 3x2 image: brightness ties, black border, extreme channels
    set_geometry(3, 2, 3);
    push_cmd(CMD_WRITE, 0, 0, '{8'd255, 8'd255, 8'd255});
    push_cmd(CMD_WRITE, 0, 1, '{8'd0, 8'd0, 8'd0});
    push_cmd(CMD_WRITE, 0, 2, '{8'd10, 8'd20, 8'd30});
    push_cmd(CMD_WRITE, 1, 0, '{8'd30, 8'd20, 8'd10});
    push_cmd(CMD_WRITE, 1, 1, '{8'd0, 8'd0, 8'd60});
    push_cmd(CMD_WRITE, 1, 2, '{8'd255, 8'd0, 8'd0});
    push_cmd(CMD_WRITE, 63, 63, '{8'd1, 8'd2, 8'd3});   // outside, dropped
    push_cmd(CMD_WRITE, 1, 3, '{8'd255, 8'd255, 8'd255});
    queue_query(0, 1);
    queue_query(1, 1);
    queue_query(63, 63);                                 // centre off image
    queue_query(0, 0);

    // empty image, oversized height, zero window
    set_geometry(0, 127, 0);
    push_cmd(CMD_WRITE, 0, 0, '{8'd255, 8'd255, 8'd255});
    queue_query(0, 0);
    queue_query(63, 0);

    // oversized width, single row, largest window
    set_geometry(127, 1, 15);
    push_cmd(CMD_WRITE, 63, 63, '{8'd255, 8'd255, 8'd255});
    queue_query(0, 0);

    while (cmds_issued < TARGET_CMDS) begin
      set_geometry(rand_dim(), rand_dim(), rand_win());
      ops = (eff_win() >= 10) ? $urandom_range(4, 12) : $urandom_range(40, 120);
      for (int i = 0; i < ops && cmds_issued < TARGET_CMDS; i++) begin
        if ($urandom_range(0, 99) < 80 && eff_rows() > 0 && eff_cols() > 0) begin
          row = $urandom_range(0, eff_rows() - 1);
          col = $urandom_range(0, eff_cols() - 1);
        end else begin
          row = $urandom_range(0, 63);
          col = $urandom_range(0, 63);
        end
        if ($urandom_range(0, 99) < 45) queue_query(row, col);
        else push_cmd(CMD_WRITE, row, col, random_pixel());
      end
    end

    while (cmds_taken != cmds_issued || median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d transactions in (%0d effective), %0d medians checked",
             cmds_taken, stim_count, medians_seen);
    $display("over %0d geometry settings, windows up to %0dx%0d, %0d errors",
             phases, widest_win, widest_win, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
